// ----- rtl/core/pgm_pkg.sv -----
// Shared package of the particle mover step core: constants, request and register codes,
// arithmetic-unit command types and the saturation and table helpers.
// Depends on nothing; the arithmetic unit, the core and the testbench take their names from here.
`timescale 1ns / 1ps

package pgm_pkg;

  // Fixed-point format and reach limit.
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] MAX_REACH = 32'd1638400;

  // CORDIC runs with 24 fraction bits of a degree; the result is rounded to FRAC_BITS.
  localparam int CORDIC_STEPS = 24;
  localparam int HSH = 24 - FRAC_BITS;
  localparam logic signed [35:0] HEAD_HALF = (36'sd1 <<< HSH) >>> 1;
  localparam logic signed [35:0] HEAD_LIM = 36'sd180 <<< FRAC_BITS;
  localparam logic signed [35:0] DEG24_90 = 36'sd1509949440;
  localparam logic signed [35:0] DEG24_180 = 36'sd3019898880;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Register reset values.
  localparam logic [30:0] OWN_MASS_RST = 31'd65536;
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd655360;
  localparam logic [30:0] GRAVITY_GAIN_RST = 31'd65536;
  localparam logic [30:0] MIN_REACH_RST = 31'd327680;
  localparam logic signed [31:0] BOUND_LEFT_RST = 32'sd0;
  localparam logic signed [31:0] BOUND_TOP_RST = 32'sd0;
  localparam logic signed [31:0] BOUND_RIGHT_RST = 32'sd41943040;
  localparam logic signed [31:0] BOUND_BOTTOM_RST = 32'sd31457280;

  typedef enum logic [2:0] {
    REQ_FORCE   = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_BOUNDS  = 3'd2,
    REQ_ATTRACT = 3'd3,
    REQ_REPEL   = 3'd4,
    REQ_PLACE   = 3'd5,
    REQ_SETVEL  = 3'd6,
    REQ_NONE    = 3'd7
  } req_code_t;

  typedef enum logic [2:0] {
    CFG_OWN_MASS     = 3'd0,
    CFG_SPEED_LIMIT  = 3'd1,
    CFG_GRAVITY_GAIN = 3'd2,
    CFG_MIN_REACH    = 3'd3,
    CFG_BOUND_LEFT   = 3'd4,
    CFG_BOUND_TOP    = 3'd5,
    CFG_BOUND_RIGHT  = 3'd6,
    CFG_BOUND_BOTTOM = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    AR_MUL  = 2'd0,
    AR_DIV  = 2'd1,
    AR_SQRT = 2'd2
  } ar_op_t;

  // Command to the serial arithmetic unit. MUL uses opa[31:0] by opb,
  // DIV divides opa by opb, SQRT takes the root of opa.
  typedef struct packed {
    logic        start;
    ar_op_t      op;
    logic [63:0] opa;
    logic [31:0] opb;
  } ar_req_t;

  // Response: res holds product, quotient or root; rem holds the remainder.
  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic [31:0] rem;
  } ar_rsp_t;

  function automatic ar_req_t ar_call(ar_op_t op, logic [63:0] opa, logic [31:0] opb);
    ar_req_t r;
    r.start = 1'b1;
    r.op = op;
    r.opa = opa;
    r.opb = opb;
    return r;
  endfunction

  function automatic logic signed [65:0] sx66(logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > sx66(S32_MAX)) r = S32_MAX;
    else if (v < sx66(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Turns an unsigned magnitude and a sign into a saturated 32-bit value.
  function automatic logic signed [31:0] apply_sign(logic [63:0] m, logic neg);
    logic signed [65:0] w;
    w = $signed({2'b00, m});
    return sat32(neg ? -w : w);
  endfunction

  // Arctangent of 2^-i in degrees with 24 fraction bits.
  function automatic logic [31:0] atan_deg24(logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489089;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509720;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/pgm_req_if.sv -----
// Request channel of the particle mover step core: valid, ready and one request beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface pgm_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [30:0]        other_mass;

  modport source(output valid, req_type, vec_x, vec_y, vec_z, other_mass, input ready);
  modport sink(input valid, req_type, vec_x, vec_y, vec_z, other_mass, output ready);
endinterface

// ----- rtl/core/pgm_res_if.sv -----
// Result channel of the particle mover step core: valid, ready and one result beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface pgm_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [24:0] heading_deg;

  modport source(output valid, force_x, force_y, force_z, pos_x, pos_y, pos_z,
                 vel_x, vel_y, vel_z, heading_deg, input ready);
  modport sink(input valid, force_x, force_y, force_z, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, heading_deg, output ready);
endinterface

// ----- rtl/core/pgm_cfg_if.sv -----
// Register write channel of the particle mover step core: valid, ready, index and data.
// Depends on nothing.
`timescale 1ns / 1ps

interface pgm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

// ----- rtl/core/pgm_arith.sv -----
// Shared bit-serial arithmetic unit: 32x32 multiply, 64/32 divide and 64-bit square root.
// Depends on pgm_pkg for the command and response types.
`timescale 1ns / 1ps

module pgm_arith (
  input  logic             clk,
  input  logic             rst,
  input  pgm_pkg::ar_req_t req,
  output pgm_pkg::ar_rsp_t rsp
);

  logic             busy;
  logic             done;
  pgm_pkg::ar_op_t  op;
  logic [5:0]       cnt;
  logic [63:0]      sh_a;
  logic [63:0]      acc;
  logic [31:0]      sh_b;
  logic [34:0]      pr;

  logic [63:0] mul_sum;
  logic [32:0] div_try;
  logic        div_ge;
  logic [34:0] sq_try;
  logic [34:0] sq_trial;
  logic        sq_ge;

  // One step of each operation: add-and-shift, restoring divide, digit-pair root.
  assign mul_sum = acc + sh_a;
  assign div_try = {pr[31:0], sh_a[63]};
  assign div_ge = div_try >= {1'b0, sh_b};
  assign sq_try = {pr[32:0], sh_a[63:62]};
  assign sq_trial = {1'b0, acc[31:0], 2'b01};
  assign sq_ge = sq_try >= sq_trial;

  assign rsp.done = done;
  assign rsp.res = acc;
  assign rsp.rem = pr[31:0];

  // Sequencer: one bit of product or quotient, or one root bit, per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op <= req.op;
        acc <= '0;
        pr <= '0;
        sh_b <= req.opb;
        unique case (req.op)
          pgm_pkg::AR_MUL: begin
            sh_a <= {32'd0, req.opa[31:0]};
            cnt <= 6'd31;
          end
          pgm_pkg::AR_DIV: begin
            sh_a <= req.opa;
            cnt <= 6'd63;
          end
          pgm_pkg::AR_SQRT: begin
            sh_a <= req.opa;
            cnt <= 6'd31;
          end
          default: begin
            sh_a <= req.opa;
            cnt <= 6'd0;
          end
        endcase
      end else if (busy) begin
        unique case (op)
          pgm_pkg::AR_MUL: begin
            if (sh_b[0]) acc <= mul_sum;
            sh_a <= {sh_a[62:0], 1'b0};
            sh_b <= {1'b0, sh_b[31:1]};
          end
          pgm_pkg::AR_DIV: begin
            if (div_ge) begin
              pr <= {3'd0, 32'(div_try - {1'b0, sh_b})};
              acc <= {acc[62:0], 1'b1};
            end else begin
              pr <= {3'd0, div_try[31:0]};
              acc <= {acc[62:0], 1'b0};
            end
            sh_a <= {sh_a[62:0], 1'b0};
          end
          pgm_pkg::AR_SQRT: begin
            if (sq_ge) begin
              pr <= sq_try - sq_trial;
              acc <= {acc[62:0], 1'b1};
            end else begin
              pr <= sq_try;
              acc <= {acc[62:0], 1'b0};
            end
            sh_a <= {sh_a[61:0], 2'b00};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A new command only arrives when the unit is free.
  a_start_free: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("arith: command issued while busy");
  // Completions never come back to back: each operation first steps through all of its bits.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("arith: two completions in a row");
  // Completion is reported only once the sequencer has stopped.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("arith: completion while still busy");

endmodule

// ----- rtl/core/particle_gravity_mover_step_core.sv -----
// Particle mover step core: one particle in signed fixed point, sequenced over a shared
// serial multiply/divide/root unit (pgm_arith) and a one-step-per-cycle CORDIC.
// Depends on pgm_pkg, pgm_req_if, pgm_res_if, pgm_cfg_if and pgm_arith.
// Place, set velocity, bounds and unused codes need no arithmetic; force divides per axis,
// tick squares per axis and the limit and adds a root and a multiply and divide per axis
// when the speed is clamped; attract and repel add a root, strength chain and axis force.
// All multiplies, divides and roots run on the one arithmetic unit; one request is in work
// at a time, so the core is ready for a new beat in the cycle after the result beat is
// registered.
// Reset (synchronous, active high) clears location, velocity, acceleration and heading,
// loads the register defaults and empties the result register.
`timescale 1ns / 1ps

module particle_gravity_mover_step_core (
  input  logic clk,
  input  logic rst,
  pgm_req_if.sink   req,
  pgm_res_if.source res,
  pgm_cfg_if.sink   cfg
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_F_ISSUE, S_F_WAIT,
    S_T_SQ_GO, S_T_SQ_W, S_T_LIM, S_T_RT, S_T_SM_GO, S_T_SM_W, S_T_SD_W,
    S_T_ADDV, S_T_ADDP, S_H_INIT, S_H_ITER, S_H_FIN,
    S_A_DIFF, S_A_SQ_GO, S_A_SQ_W, S_A_RT_GO, S_A_RT_W, S_A_DIST, S_A_GM_W,
    S_A_B_W, S_A_Q_W, S_A_P_W, S_A_R_W, S_A_T_W, S_A_F_GO, S_A_FM_W, S_A_FD_W,
    S_FIN
  } state_t;

  state_t state;
  pgm_pkg::req_code_t code;
  logic [1:0] k;
  logic [4:0] it;

  // Particle state.
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] acc [3];
  logic signed [24:0] heading;

  // Registers.
  logic [30:0]        own_mass;
  logic [30:0]        speed_limit;
  logic [30:0]        gravity_gain;
  logic [30:0]        min_reach;
  logic signed [31:0] bound_left;
  logic signed [31:0] bound_top;
  logic signed [31:0] bound_right;
  logic signed [31:0] bound_bottom;

  // Working registers of the current request.
  logic signed [31:0] vin [3];
  logic signed [31:0] dvec [3];
  logic signed [31:0] frc [3];
  logic [30:0]        omass_in;
  logic [63:0]        sum;
  logic [63:0]        prod;
  logic [31:0]        rmd;
  logic [31:0]        len;
  logic [31:0]        reach;
  logic [30:0]        strength;
  logic signed [59:0] cx;
  logic signed [59:0] cy;
  logic signed [35:0] cz;

  pgm_pkg::ar_req_t ar_req;
  pgm_pkg::ar_rsp_t ar_rsp;

  pgm_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (ar_req),
    .rsp (ar_rsp)
  );

  // Per-axis operands and helpers.
  logic [31:0]        mag_v;
  logic [31:0]        mag_d;
  logic [31:0]        mag_in;
  logic signed [31:0] zero_mass_q;
  logic signed [31:0] f_quot;
  logic [31:0]        dist_lo;
  logic [31:0]        dist_hi;
  logic [31:0]        dist_new;
  logic [64:0]        str_sum;
  logic signed [59:0] xs;
  logic signed [59:0] ys;
  logic signed [35:0] atan_s;
  logic signed [59:0] vx_wide;
  logic signed [59:0] vy_wide;
  logic signed [35:0] z_rnd;
  logic signed [35:0] z_clamp;

  assign mag_v = pgm_pkg::mag32(vel[k]);
  assign mag_d = pgm_pkg::mag32(dvec[k]);
  assign mag_in = pgm_pkg::mag32(vin[k]);
  assign zero_mass_q = vin[k][31] ? pgm_pkg::S32_MIN :
                       ((vin[k] != 32'sd0) ? pgm_pkg::S32_MAX : 32'sd0);
  assign f_quot = pgm_pkg::apply_sign(ar_rsp.res, vin[k][31]);

  // Distance clamp: raise to the minimum reach, lower to the maximum, never zero.
  assign dist_lo = (len < {1'b0, min_reach}) ? {1'b0, min_reach} : len;
  assign dist_hi = (dist_lo > pgm_pkg::MAX_REACH) ? pgm_pkg::MAX_REACH : dist_lo;
  assign dist_new = (dist_hi == 32'd0) ? 32'd1 : dist_hi;
  assign str_sum = {1'b0, prod} + {1'b0, ar_rsp.res};

  // CORDIC step operands.
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign atan_s = $signed({4'd0, pgm_pkg::atan_deg24(it)});
  assign vx_wide = {{4{vel[0][31]}}, vel[0], 24'd0};
  assign vy_wide = {{4{vel[1][31]}}, vel[1], 24'd0};
  assign z_rnd = (cz + pgm_pkg::HEAD_HALF) >>> pgm_pkg::HSH;
  assign z_clamp = (z_rnd > pgm_pkg::HEAD_LIM) ? pgm_pkg::HEAD_LIM :
                   ((z_rnd < -pgm_pkg::HEAD_LIM) ? -pgm_pkg::HEAD_LIM : z_rnd);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // Request sequencer, particle state, registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ar_req.start <= 1'b0;
      res.valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        acc[i] <= '0;
      end
      heading <= '0;
      own_mass <= pgm_pkg::OWN_MASS_RST;
      speed_limit <= pgm_pkg::SPEED_LIMIT_RST;
      gravity_gain <= pgm_pkg::GRAVITY_GAIN_RST;
      min_reach <= pgm_pkg::MIN_REACH_RST;
      bound_left <= pgm_pkg::BOUND_LEFT_RST;
      bound_top <= pgm_pkg::BOUND_TOP_RST;
      bound_right <= pgm_pkg::BOUND_RIGHT_RST;
      bound_bottom <= pgm_pkg::BOUND_BOTTOM_RST;
    end else begin
      ar_req.start <= 1'b0;
      if (res.valid && res.ready && state != S_FIN) res.valid <= 1'b0;

      // Register writes.
      if (cfg.valid) begin
        unique case (pgm_pkg::cfg_index_t'(cfg.reg_index))
          pgm_pkg::CFG_OWN_MASS:     own_mass <= cfg.data[30:0];
          pgm_pkg::CFG_SPEED_LIMIT:  speed_limit <= cfg.data[30:0];
          pgm_pkg::CFG_GRAVITY_GAIN: gravity_gain <= cfg.data[30:0];
          pgm_pkg::CFG_MIN_REACH:    min_reach <= cfg.data[30:0];
          pgm_pkg::CFG_BOUND_LEFT:   bound_left <= cfg.data;
          pgm_pkg::CFG_BOUND_TOP:    bound_top <= cfg.data;
          pgm_pkg::CFG_BOUND_RIGHT:  bound_right <= cfg.data;
          pgm_pkg::CFG_BOUND_BOTTOM: bound_bottom <= cfg.data;
          default: own_mass <= own_mass;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            code <= pgm_pkg::req_code_t'(req.req_type);
            vin[0] <= req.vec_x;
            vin[1] <= req.vec_y;
            vin[2] <= req.vec_z;
            omass_in <= req.other_mass;
            for (int i = 0; i < 3; i++) frc[i] <= '0;
            state <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          k <= 2'd0;
          sum <= '0;
          unique case (code)
            pgm_pkg::REQ_FORCE: state <= S_F_ISSUE;
            pgm_pkg::REQ_TICK: state <= S_T_SQ_GO;
            pgm_pkg::REQ_BOUNDS: begin
              if (pos[0] < bound_left || pos[0] > bound_right)
                vel[0] <= pgm_pkg::sat32(-pgm_pkg::sx66(vel[0]));
              if (pos[1] < bound_top || pos[1] > bound_bottom)
                vel[1] <= pgm_pkg::sat32(-pgm_pkg::sx66(vel[1]));
              state <= S_FIN;
            end
            pgm_pkg::REQ_ATTRACT, pgm_pkg::REQ_REPEL: state <= S_A_DIFF;
            pgm_pkg::REQ_PLACE: begin
              for (int i = 0; i < 3; i++) pos[i] <= vin[i];
              state <= S_FIN;
            end
            pgm_pkg::REQ_SETVEL: begin
              for (int i = 0; i < 3; i++) vel[i] <= vin[i];
              state <= S_FIN;
            end
            pgm_pkg::REQ_NONE: state <= S_FIN;
            default: state <= S_FIN;
          endcase
        end

        // Force: acceleration += force times 2^16 over mass; zero mass saturates by sign.
        S_F_ISSUE: begin
          if (own_mass == 31'd0) begin
            acc[k] <= pgm_pkg::sat32(pgm_pkg::sx66(acc[k]) + pgm_pkg::sx66(zero_mass_q));
            if (k == 2'd2) state <= S_FIN;
            else k <= k + 2'd1;
          end else begin
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_DIV,
                                       {32'd0, mag_in} << pgm_pkg::FRAC_BITS,
                                       {1'b0, own_mass});
            state <= S_F_WAIT;
          end
        end
        S_F_WAIT: begin
          if (ar_rsp.done) begin
            acc[k] <= pgm_pkg::sat32(pgm_pkg::sx66(acc[k]) + pgm_pkg::sx66(f_quot));
            if (k == 2'd2) state <= S_FIN;
            else begin
              k <= k + 2'd1;
              state <= S_F_ISSUE;
            end
          end
        end

        // Tick: squared speed against the squared limit.
        S_T_SQ_GO: begin
          ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {32'd0, mag_v}, mag_v);
          state <= S_T_SQ_W;
        end
        S_T_SQ_W: begin
          if (ar_rsp.done) begin
            sum <= sum + ar_rsp.res;
            if (k == 2'd2) begin
              ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {33'd0, speed_limit},
                                         {1'b0, speed_limit});
              state <= S_T_LIM;
            end else begin
              k <= k + 2'd1;
              state <= S_T_SQ_GO;
            end
          end
        end
        S_T_LIM: begin
          if (ar_rsp.done) begin
            if (sum > ar_rsp.res) begin
              ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_SQRT, sum, 32'd0);
              state <= S_T_RT;
            end else begin
              state <= S_T_ADDV;
            end
          end
        end
        S_T_RT: begin
          if (ar_rsp.done) begin
            len <= ar_rsp.res[31:0];
            k <= 2'd0;
            state <= S_T_SM_GO;
          end
        end
        // Speed clamp: each component scaled by limit over magnitude.
        S_T_SM_GO: begin
          ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {32'd0, mag_v}, {1'b0, speed_limit});
          state <= S_T_SM_W;
        end
        S_T_SM_W: begin
          if (ar_rsp.done) begin
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_DIV, ar_rsp.res, len);
            state <= S_T_SD_W;
          end
        end
        S_T_SD_W: begin
          if (ar_rsp.done) begin
            vel[k] <= pgm_pkg::apply_sign(ar_rsp.res, vel[k][31]);
            if (k == 2'd2) state <= S_T_ADDV;
            else begin
              k <= k + 2'd1;
              state <= S_T_SM_GO;
            end
          end
        end
        S_T_ADDV: begin
          for (int i = 0; i < 3; i++)
            vel[i] <= pgm_pkg::sat32(pgm_pkg::sx66(vel[i]) + pgm_pkg::sx66(acc[i]));
          state <= S_T_ADDP;
        end
        S_T_ADDP: begin
          for (int i = 0; i < 3; i++) begin
            pos[i] <= pgm_pkg::sat32(pgm_pkg::sx66(pos[i]) + pgm_pkg::sx66(vel[i]));
            acc[i] <= '0;
          end
          state <= S_H_INIT;
        end

        // Heading: exact axes first, otherwise fold into the right half-plane and rotate.
        S_H_INIT: begin
          it <= 5'd0;
          if (vel[1] == 32'sd0) begin
            cz <= (vel[0][31]) ? pgm_pkg::DEG24_180 : 36'sd0;
            state <= S_H_FIN;
          end else if (vel[0] == 32'sd0) begin
            cz <= (vel[1][31]) ? -pgm_pkg::DEG24_90 : pgm_pkg::DEG24_90;
            state <= S_H_FIN;
          end else begin
            if (vel[0][31]) begin
              cx <= -vx_wide;
              cy <= -vy_wide;
              cz <= (vel[1][31]) ? -pgm_pkg::DEG24_180 : pgm_pkg::DEG24_180;
            end else begin
              cx <= vx_wide;
              cy <= vy_wide;
              cz <= 36'sd0;
            end
            state <= S_H_ITER;
          end
        end
        S_H_ITER: begin
          if (cy > 60'sd0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_s;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_s;
          end
          it <= it + 5'd1;
          if (it == 5'(pgm_pkg::CORDIC_STEPS - 1)) state <= S_H_FIN;
        end
        S_H_FIN: begin
          heading <= 25'(pgm_pkg::sat32({{30{z_clamp[35]}}, z_clamp}));
          state <= S_FIN;
        end

        // Attract and repel: difference vector and its length.
        S_A_DIFF: begin
          for (int i = 0; i < 3; i++)
            dvec[i] <= pgm_pkg::sat32(pgm_pkg::sx66(pos[i]) - pgm_pkg::sx66(vin[i]));
          state <= S_A_SQ_GO;
        end
        S_A_SQ_GO: begin
          ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {32'd0, mag_d}, mag_d);
          state <= S_A_SQ_W;
        end
        S_A_SQ_W: begin
          if (ar_rsp.done) begin
            sum <= sum + ar_rsp.res;
            if (k == 2'd2) state <= S_A_RT_GO;
            else begin
              k <= k + 2'd1;
              state <= S_A_SQ_GO;
            end
          end
        end
        S_A_RT_GO: begin
          ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_SQRT, sum, 32'd0);
          state <= S_A_RT_W;
        end
        S_A_RT_W: begin
          if (ar_rsp.done) begin
            len <= ar_rsp.res[31:0];
            state <= S_A_DIST;
          end
        end
        // Strength: G times own mass over distance, over distance again, times other mass.
        S_A_DIST: begin
          reach <= dist_new;
          ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {33'd0, gravity_gain}, {1'b0, own_mass});
          state <= S_A_GM_W;
        end
        S_A_GM_W: begin
          if (ar_rsp.done) begin
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_DIV, ar_rsp.res, reach);
            state <= S_A_B_W;
          end
        end
        S_A_B_W: begin
          if (ar_rsp.done) begin
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_DIV, ar_rsp.res, reach);
            state <= S_A_Q_W;
          end
        end
        S_A_Q_W: begin
          if (ar_rsp.done) begin
            rmd <= ar_rsp.rem;
            k <= 2'd0;
            if (omass_in == 31'd0) begin
              strength <= '0;
              state <= S_A_F_GO;
            end else if (ar_rsp.res[63:31] != 33'd0) begin
              strength <= pgm_pkg::S32_MAX[30:0];
              state <= S_A_F_GO;
            end else begin
              ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {32'd0, ar_rsp.res[31:0]},
                                         {1'b0, omass_in});
              state <= S_A_P_W;
            end
          end
        end
        S_A_P_W: begin
          if (ar_rsp.done) begin
            prod <= ar_rsp.res;
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {32'd0, rmd}, {1'b0, omass_in});
            state <= S_A_R_W;
          end
        end
        S_A_R_W: begin
          if (ar_rsp.done) begin
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_DIV, ar_rsp.res, reach);
            state <= S_A_T_W;
          end
        end
        S_A_T_W: begin
          if (ar_rsp.done) begin
            if (str_sum > {34'd0, pgm_pkg::S32_MAX[30:0]}) strength <= pgm_pkg::S32_MAX[30:0];
            else strength <= str_sum[30:0];
            state <= S_A_F_GO;
          end
        end
        // Force components: difference times strength over length, negated for repel.
        S_A_F_GO: begin
          if (len == 32'd0) state <= S_FIN;
          else begin
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_MUL, {32'd0, mag_d}, {1'b0, strength});
            state <= S_A_FM_W;
          end
        end
        S_A_FM_W: begin
          if (ar_rsp.done) begin
            ar_req <= pgm_pkg::ar_call(pgm_pkg::AR_DIV, ar_rsp.res, len);
            state <= S_A_FD_W;
          end
        end
        S_A_FD_W: begin
          if (ar_rsp.done) begin
            frc[k] <= pgm_pkg::apply_sign(ar_rsp.res,
                                          dvec[k][31] ^ (code == pgm_pkg::REQ_REPEL));
            if (k == 2'd2) state <= S_FIN;
            else begin
              k <= k + 2'd1;
              state <= S_A_F_GO;
            end
          end
        end

        // Hand the result beat to the output register once it is free.
        S_FIN: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.force_x <= frc[0];
            res.force_y <= frc[1];
            res.force_z <= frc[2];
            res.pos_x <= pos[0];
            res.pos_y <= pos[1];
            res.pos_z <= pos[2];
            res.vel_x <= vel[0];
            res.vel_y <= vel[1];
            res.vel_z <= vel[2];
            res.heading_deg <= heading;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Commands to the arithmetic unit are single-cycle pulses.
  a_cmd_pulse: assert property (@(posedge clk) disable iff (rst) ar_req.start |=> !ar_req.start)
    else $error("core: arithmetic command held for two cycles");
  // Once a request beat is taken, no further beat is taken until it is finished.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
                               (req.valid && req.ready) |=> !req.ready)
    else $error("core: request taken while busy");
  // The heading changes only in the final CORDIC rounding step.
  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
                                   (state != S_H_FIN) |=> $stable(heading))
    else $error("core: heading changed outside its update");

endmodule

// ----- tb/particle_gravity_mover_step_core_test.sv -----
// Self-checking testbench of the particle mover step core: random-idling request driver,
// result monitor with random back-pressure, and a bit-exact predictor of the particle state.
// Depends on pgm_pkg, pgm_req_if, pgm_res_if, pgm_cfg_if and particle_gravity_mover_step_core.
`timescale 1ns / 1ps

module particle_gravity_mover_step_core_test;
  import pgm_pkg::*;

  typedef struct {
    req_code_t          kind;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [30:0]        om;
  } motion_req_t;

  typedef struct {
    logic signed [31:0] fx, fy, fz;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] vx, vy, vz;
    logic [24:0]        hd;
  } particle_beat_t;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pgm_req_if rq();
  pgm_res_if rs();
  pgm_cfg_if cf();

  particle_gravity_mover_step_core dut (
    .clk(clk), .rst(rst), .req(rq), .res(rs), .cfg(cf)
  );

  always #5 clk = ~clk;

  // Predicted particle state and register copy.
  logic [30:0]        m_mass, m_speed_lim, m_gain, m_min_reach;
  logic signed [31:0] m_left, m_top, m_right, m_bottom;
  logic signed [31:0] m_pos[3], m_vel[3], m_acc[3], m_heading;

  motion_req_t    pending_reqs[$];
  particle_beat_t expected_beats[$];
  motion_req_t    cur;
  int             req_gap = 0;
  int             res_hold = 0;
  bit             quiet = 1'b0;
  int             mismatches = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > SMAX) return SMAX[31:0];
    if (v < SMIN) return SMIN[31:0];
    return v[31:0];
  endfunction

  function automatic longint unsigned square_of(logic signed [31:0] v);
    longint unsigned m;
    m = (v < 0) ? longint'(-longint'(v)) : longint'(v);
    return m * m;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Heading by CORDIC in degrees with 24 fraction bits, rounded to the output format.
  function automatic logic signed [31:0] heading_from(logic signed [31:0] vx,
                                                      logic signed [31:0] vy);
    longint z, x, y, xs, ys, lim;
    longint tbl[24];
    tbl = '{754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
            58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    if (vy == 0) begin
      z = (vx >= 0) ? 64'sd0 : 64'sd3019898880;
    end else if (vx == 0) begin
      z = (vy > 0) ? 64'sd1509949440 : -64'sd1509949440;
    end else begin
      x = longint'(vx) * 16777216;
      y = longint'(vy) * 16777216;
      z = 0;
      if (x < 0) begin
        z = (y > 0) ? 64'sd3019898880 : -64'sd3019898880;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + tbl[i];
        end else begin
          x = x - ys; y = y + xs; z = z - tbl[i];
        end
      end
    end
    z = (z + 128) >>> 8;
    lim = 64'sd180 <<< 16;
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    return clamp32(z);
  endfunction

  // Applies one request to the predicted state and returns the beat it should produce.
  function automatic particle_beat_t advance_particle(motion_req_t r);
    particle_beat_t b;
    logic signed [31:0] v[3], f[3], d[3];
    longint q, mg, fl;
    longint unsigned sum, lim, len, reach, bq, qq, rr, s, om;
    v = '{r.vx, r.vy, r.vz};
    f = '{0, 0, 0};
    om = longint'(r.om);
    case (r.kind)
      REQ_FORCE: begin
        for (int i = 0; i < 3; i++) begin
          if (m_mass == 0) q = (v[i] > 0) ? SMAX : ((v[i] < 0) ? SMIN : 64'sd0);
          else q = (longint'(v[i]) * 65536) / longint'(m_mass);
          m_acc[i] = clamp32(longint'(m_acc[i]) + longint'(clamp32(q)));
        end
      end
      REQ_TICK: begin
        sum = square_of(m_vel[0]) + square_of(m_vel[1]) + square_of(m_vel[2]);
        lim = longint'(m_speed_lim);
        if (sum > lim * lim) begin
          mg = longint'(root_floor(sum));
          for (int i = 0; i < 3; i++)
            m_vel[i] = clamp32((longint'(m_vel[i]) * longint'(lim)) / mg);
        end
        for (int i = 0; i < 3; i++) begin
          m_vel[i] = clamp32(longint'(m_vel[i]) + longint'(m_acc[i]));
          m_pos[i] = clamp32(longint'(m_pos[i]) + longint'(m_vel[i]));
          m_acc[i] = 0;
        end
        m_heading = heading_from(m_vel[0], m_vel[1]);
      end
      REQ_BOUNDS: begin
        if (m_pos[0] < m_left || m_pos[0] > m_right) m_vel[0] = clamp32(-longint'(m_vel[0]));
        if (m_pos[1] < m_top || m_pos[1] > m_bottom) m_vel[1] = clamp32(-longint'(m_vel[1]));
      end
      REQ_ATTRACT, REQ_REPEL: begin
        for (int i = 0; i < 3; i++) d[i] = clamp32(longint'(m_pos[i]) - longint'(v[i]));
        len = root_floor(square_of(d[0]) + square_of(d[1]) + square_of(d[2]));
        reach = (len < longint'(m_min_reach)) ? longint'(m_min_reach) : len;
        if (reach > longint'(MAX_REACH)) reach = longint'(MAX_REACH);
        if (reach == 0) reach = 1;
        bq = (longint'(m_gain) * longint'(m_mass)) / reach;
        qq = bq / reach;
        rr = bq % reach;
        if (qq > 0 && om > 0 && qq > longint'(SMAX) / om) begin
          s = SMAX;
        end else begin
          s = qq * om + (rr * om) / reach;
          if (s > longint'(SMAX)) s = SMAX;
        end
        if (len != 0) begin
          for (int i = 0; i < 3; i++) begin
            fl = (longint'(d[i]) * longint'(s)) / longint'(len);
            f[i] = clamp32((r.kind == REQ_REPEL) ? -fl : fl);
          end
        end
      end
      REQ_PLACE:  m_pos = v;
      REQ_SETVEL: m_vel = v;
      default: ;
    endcase
    b.fx = f[0]; b.fy = f[1]; b.fz = f[2];
    b.px = m_pos[0]; b.py = m_pos[1]; b.pz = m_pos[2];
    b.vx = m_vel[0]; b.vy = m_vel[1]; b.vz = m_vel[2];
    b.hd = m_heading[24:0];
    return b;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 1'b1;
    if (mismatches < 10)
      $display("mismatch on %s: expected %h, got %h at %0t", name, want, got, $realtime);
    return 1'b0;
  endfunction

  // Request driver: takes the next pending request when the slot is free, with random idle gaps.
  always @(posedge clk) begin
    if (rst) begin
      rq.valid <= 1'b0;
    end else begin
      if (rq.valid && rq.ready) expected_beats.push_back(advance_particle(cur));
      if (!rq.valid || rq.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          rq.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          req_gap = $urandom_range(1, 17) - 1;
          rq.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          rq.req_type <= cur.kind;
          rq.vec_x <= cur.vx;
          rq.vec_y <= cur.vy;
          rq.vec_z <= cur.vz;
          rq.other_mass <= cur.om;
          rq.valid <= 1'b1;
        end else begin
          rq.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random stalls on ready, each beat checked against the oldest prediction.
  always @(posedge clk) begin
    particle_beat_t e;
    bit ok;
    if (rst) begin
      rs.ready <= 1'b0;
    end else begin
      if (rs.valid && rs.ready) begin
        if (expected_beats.size() == 0) begin
          if (mismatches < 10) $display("result beat with nothing expected at %0t", $realtime);
          mismatches++;
        end else begin
          e = expected_beats.pop_front();
          ok = field_ok("force_x", e.fx, rs.force_x);
          ok = field_ok("force_y", e.fy, rs.force_y) && ok;
          ok = field_ok("force_z", e.fz, rs.force_z) && ok;
          ok = field_ok("pos_x", e.px, rs.pos_x) && ok;
          ok = field_ok("pos_y", e.py, rs.pos_y) && ok;
          ok = field_ok("pos_z", e.pz, rs.pos_z) && ok;
          ok = field_ok("vel_x", e.vx, rs.vel_x) && ok;
          ok = field_ok("vel_y", e.vy, rs.vel_y) && ok;
          ok = field_ok("vel_z", e.vz, rs.vel_z) && ok;
          ok = field_ok("heading_deg", {7'd0, e.hd}, {7'd0, rs.heading_deg}) && ok;
          if (!ok) mismatches++;
        end
      end
      if (res_hold > 0) begin
        res_hold--;
        rs.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        res_hold = $urandom_range(1, 17) - 1;
        rs.ready <= 1'b0;
      end else begin
        rs.ready <= 1'b1;
      end
    end
  end

  task automatic add_req(req_code_t k, logic signed [31:0] x, logic signed [31:0] y,
                         logic signed [31:0] z, logic [30:0] om);
    motion_req_t r;
    r.kind = k; r.vx = x; r.vy = y; r.vz = z; r.om = om;
    pending_reqs.push_back(r);
  endtask

  // Register write at an idle point; the predictor copy follows the accepted beat.
  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cf.reg_index <= idx;
    cf.data <= val;
    cf.valid <= 1'b1;
    do @(posedge clk); while (!cf.ready);
    cf.valid <= 1'b0;
    case (idx)
      CFG_OWN_MASS:     m_mass = val[30:0];
      CFG_SPEED_LIMIT:  m_speed_lim = val[30:0];
      CFG_GRAVITY_GAIN: m_gain = val[30:0];
      CFG_MIN_REACH:    m_min_reach = val[30:0];
      CFG_BOUND_LEFT:   m_left = val;
      CFG_BOUND_TOP:    m_top = val;
      CFG_BOUND_RIGHT:  m_right = val;
      default:          m_bottom = val;
    endcase
  endtask

  // Waits until nothing is queued, offered or in flight; the second look catches a beat
  // that the driver picked up on the same edge as the first look.
  task automatic wait_idle();
    do begin
      while (pending_reqs.size() != 0 || expected_beats.size() != 0 || rq.valid)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end while (pending_reqs.size() != 0 || expected_beats.size() != 0 || rq.valid);
  endtask

  function automatic logic signed [31:0] spread(int unsigned mag);
    logic signed [31:0] a;
    a = $urandom_range(0, mag);
    return $urandom_range(0, 1) ? -a : a;
  endfunction

  function automatic logic signed [31:0] pick(int unsigned mag);
    return ($urandom_range(0, 9) == 0) ? $urandom : spread(mag);
  endfunction

  // Random request: mostly plausible motion with the odd full-range or unused beat.
  task automatic add_random_req();
    int w;
    logic [30:0] om;
    w = $urandom_range(0, 99);
    om = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
    if (w < 30) add_req(REQ_TICK, $urandom, $urandom, $urandom, 31'($urandom));
    else if (w < 45) add_req(REQ_FORCE, pick(1 << 20), pick(1 << 20), pick(1 << 18), om);
    else if (w < 57) add_req(REQ_SETVEL, pick(1 << 21), pick(1 << 21), pick(1 << 19), om);
    else if (w < 67) add_req(REQ_PLACE, pick(1 << 26), pick(1 << 26), pick(1 << 22), om);
    else if (w < 79) add_req(REQ_BOUNDS, $urandom, $urandom, $urandom, 31'($urandom));
    else if (w < 88) add_req(REQ_ATTRACT, pick(1 << 24), pick(1 << 24), pick(1 << 22), om);
    else if (w < 96) add_req(REQ_REPEL, pick(1 << 24), pick(1 << 24), pick(1 << 22), om);
    else add_req(REQ_NONE, $urandom, $urandom, $urandom, 31'($urandom));
  endtask

  // Phase registers, the extremes among them.
  task automatic setup_phase(int p);
    logic [31:0] v[8];
    case (p)
      1: v = '{$urandom_range(1, 1 << 20), $urandom_range(1 << 16, 1 << 22),
               $urandom_range(0, 1 << 20), $urandom_range(1 << 14, 1 << 20),
               -$urandom_range(0, 1 << 24), -$urandom_range(0, 1 << 24),
               $urandom_range(1 << 22, 1 << 26), $urandom_range(1 << 22, 1 << 26)};
      2: v = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      3: v = '{32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0};
      4: v = '{32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
      default: v = '{$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_index_t'(i), v[i]);
  endtask

  initial begin
    rq.valid = 1'b0; rq.req_type = REQ_NONE; rq.vec_x = 0; rq.vec_y = 0; rq.vec_z = 0;
    rq.other_mass = 0;
    rs.ready = 1'b0;
    cf.valid = 1'b0; cf.reg_index = CFG_OWN_MASS; cf.data = 0;
    m_mass = OWN_MASS_RST; m_speed_lim = SPEED_LIMIT_RST; m_gain = GRAVITY_GAIN_RST;
    m_min_reach = MIN_REACH_RST;
    m_left = BOUND_LEFT_RST; m_top = BOUND_TOP_RST;
    m_right = BOUND_RIGHT_RST; m_bottom = BOUND_BOTTOM_RST;
    m_pos = '{0, 0, 0}; m_vel = '{0, 0, 0}; m_acc = '{0, 0, 0}; m_heading = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset registers.
    add_req(REQ_ATTRACT, 0, 0, 0, 31'h7FFF_FFFF);          // zero length
    add_req(REQ_SETVEL, S32_MAX, S32_MAX, S32_MAX, 0);
    add_req(REQ_TICK, 0, 0, 0, 0);                          // speed clamp
    add_req(REQ_FORCE, S32_MAX, S32_MIN, 0, 0);
    add_req(REQ_FORCE, S32_MAX, S32_MIN, -1, 0);            // saturating accumulate
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_SETVEL, 0, -32'sd5, 0, 0);                  // straight down
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_SETVEL, -32'sd65536, 0, 0, 0);              // straight back
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_SETVEL, -32'sd70000, 32'sd30000, 7, 0);
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_SETVEL, 32'sd1, -32'sd1, 0, 0);
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_PLACE, -32'sd65536, 32'sd40000000, 5, 0);   // outside the box
    add_req(REQ_SETVEL, S32_MIN, S32_MIN, S32_MIN, 0);
    add_req(REQ_BOUNDS, 0, 0, 0, 0);                        // negating the minimum
    add_req(REQ_ATTRACT, S32_MAX, S32_MIN, S32_MAX, 31'h7FFF_FFFF);
    add_req(REQ_REPEL, -32'sd65536, 32'sd40100000, 5, 31'd65536);
    add_req(REQ_ATTRACT, 32'sd1000000, 32'sd39000000, 0, 31'd655360);
    add_req(REQ_NONE, S32_MAX, S32_MIN, -1, 31'h7FFF_FFFF);
    add_req(REQ_PLACE, 0, 0, 0, 0);
    wait_idle();

    for (int p = 1; p <= 5; p++) begin
      setup_phase(p);
      if (p == 5) quiet = 1'b1;
      add_req(REQ_PLACE, 0, 0, 0, 0);
      add_req(REQ_ATTRACT, 0, 0, 0, 31'($urandom));          // zero distance
      add_req(REQ_FORCE, $urandom, -32'sd3, 0, 0);
      for (int n = 0; n < 150; n++) add_random_req();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("particle_gravity_mover_step_core_test: PASS");
    end else begin
      $display("particle_gravity_mover_step_core_test: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("particle_gravity_mover_step_core_test: FAIL");
    $finish;
  end

endmodule
